// ----- src/rfa_pkg.sv -----
package rfa_pkg;

    localparam int OP_W  = 3;
    localparam int NUM_W = 33;
    localparam int DEN_W = 31;
    localparam int MAG_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_SUB    = 3'd1,
        OP_MUL    = 3'd2,
        OP_DIV    = 3'd3,
        OP_REDUCE = 3'd4,
        OP_CMP    = 3'd5
    } op_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic combine;
        logic gcd_init;
        logic gcd_step;
        logic div_init;
        logic div_step;
    } rfa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic early;
        logic gcd_done;
        logic div_done;
    } rfa_sts_t;

endpackage

// ----- src/rational_fraction_alu_core.sv -----
// channel | valid     | stall     | word
// in      | in_valid  | in_stall  | operation, first/second num/den
// out     | out_valid | out_stall | result_num, result_den, status, order
// One word at a time: load, multiply, combine, binary gcd, then two
// bit-serial exact divides (numerator, then denominator).
// Zero or infinite results skip the gcd and the divides.
// Reset clears the sequencer only. A stalled result holds; no new word taken.
module rational_fraction_alu_core
    import rfa_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [OP_W-1:0]                 operation,
    input  logic signed [OPERAND_WIDTH-1:0] first_num,
    input  logic signed [OPERAND_WIDTH-1:0] first_den,
    input  logic signed [OPERAND_WIDTH-1:0] second_num,
    input  logic signed [OPERAND_WIDTH-1:0] second_den,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [NUM_W-1:0]         result_num,
    output logic [DEN_W-1:0]                result_den,
    output logic                            status,
    output logic signed [1:0]               order
);

    rfa_cmd_t cmd;
    rfa_sts_t sts;

    rfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    rfa_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .sts        (sts),
        .operation  (operation),
        .first_num  (first_num),
        .first_den  (first_den),
        .second_num (second_num),
        .second_den (second_den),
        .result_num (result_num),
        .result_den (result_den),
        .status     (status),
        .order      (order)
    );

endmodule

// ----- src/rfa_ctrl.sv -----
module rfa_ctrl
    import rfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  rfa_sts_t sts,
    output rfa_cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_COMB = 7'b0000100,
        S_GINI = 7'b0001000,
        S_GCD  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_COMB;
            end
            S_COMB:
            begin
                cmd.combine = 1'b1;
                state_next  = S_GINI;
            end
            S_GINI:
            begin
                if (sts.early)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.gcd_init = 1'b1;
                    state_next   = S_GCD;
                end
            end
            S_GCD:
            begin
                if (sts.gcd_done)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

endmodule

// ----- src/rfa_datapath.sv -----
module rfa_datapath
    import rfa_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
)
(
    input  logic                            clk,
    input  rfa_cmd_t                        cmd,
    output rfa_sts_t                        sts,
    input  logic [OP_W-1:0]                 operation,
    input  logic signed [OPERAND_WIDTH-1:0] first_num,
    input  logic signed [OPERAND_WIDTH-1:0] first_den,
    input  logic signed [OPERAND_WIDTH-1:0] second_num,
    input  logic signed [OPERAND_WIDTH-1:0] second_den,
    output logic signed [NUM_W-1:0]         result_num,
    output logic [DEN_W-1:0]                result_den,
    output logic                            status,
    output logic signed [1:0]               order
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * OPERAND_WIDTH;
    localparam int SW = PW + 1;
    localparam int CW = $clog2(PW + 1);

    logic [OP_W-1:0] op_reg;
    logic [W-1:0]    ma_reg, mb_reg, mc_reg, md_reg;
    logic            s1_reg, s2_reg;
    logic [PW-1:0]   p0_reg, p1_reg, p2_reg;
    logic [SW-1:0]   num_reg;
    logic [PW-1:0]   den_reg;
    logic            rs_reg, inf_reg;
    logic [1:0]      ord_reg;
    logic [SW-1:0]   x_reg, y_reg;
    logic [CW-1:0]   sh_reg;
    logic            gph_reg;
    logic [SW-1:0]   g_reg;
    logic [SW-1:0]   rem_reg, quo_reg;
    logic [CW:0]     cnt_reg;
    logic            dsel_reg;
    logic [SW-1:0]   qn_reg;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // products: mul state forms a*d / c*b / b*d or per op
    logic [PW-1:0] m0, m1, m2;
    logic [SW-1:0] cs_num;
    logic          cs_sign;
    logic          s2x;

    always_comb
    begin
        m0 = PW'(ma_reg) * PW'(md_reg);
        m1 = PW'(mc_reg) * PW'(mb_reg);
        m2 = PW'(mb_reg) * PW'(md_reg);
        if (op_reg == OP_MUL)
        begin
            m0 = PW'(ma_reg) * PW'(mc_reg);
        end
        else if (op_reg == OP_DIV)
        begin
            m2 = PW'(mb_reg) * PW'(mc_reg);
        end
        s2x = (op_reg == OP_ADD) ? s2_reg : !s2_reg;
        if (s1_reg == s2x)
        begin
            cs_num  = SW'(p0_reg) + SW'(p1_reg);
            cs_sign = s1_reg;
        end
        else if (p0_reg >= p1_reg)
        begin
            cs_num  = SW'(p0_reg - p1_reg);
            cs_sign = s1_reg;
        end
        else
        begin
            cs_num  = SW'(p1_reg - p0_reg);
            cs_sign = s2x;
        end
    end

    logic [SW-1:0] ys, xs, yd;
    always_comb
    begin
        ys = y_reg >> 1;
        xs = x_reg;
        yd = y_reg;
        if (y_reg > x_reg)
        begin
            yd = y_reg - x_reg;
        end
        else
        begin
            xs = y_reg;
            yd = x_reg - y_reg;
        end
    end

    // dividend bit brought down this step, msb first
    logic [SW-1:0] div_src;
    logic [CW-1:0] div_idx;
    logic          div_bit;
    logic [SW:0]   trial;
    assign div_src = dsel_reg ? SW'(den_reg) : num_reg;
    assign div_idx = CW'(SW - 1) - cnt_reg[CW-1:0];
    assign div_bit = div_src[div_idx];
    assign trial   = {rem_reg, div_bit} - {1'b0, g_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= operation;
            ma_reg <= mag_of(first_num);
            mb_reg <= mag_of(first_den);
            mc_reg <= mag_of(second_num);
            md_reg <= mag_of(second_den);
            s1_reg <= first_num[W-1] ^ first_den[W-1];
            s2_reg <= second_num[W-1] ^ second_den[W-1];
        end
        if (cmd.mul)
        begin
            p0_reg <= m0;
            p1_reg <= m1;
            p2_reg <= m2;
        end
        if (cmd.combine)
        begin
            inf_reg <= 1'b0;
            ord_reg <= 2'b00;
            rs_reg  <= 1'b0;
            num_reg <= '0;
            den_reg <= PW'(1);
            case (op_reg)
                OP_REDUCE:
                begin
                    if (mb_reg == '0)
                    begin
                        inf_reg <= 1'b1;
                    end
                    else
                    begin
                        num_reg <= SW'(ma_reg);
                        den_reg <= PW'(mb_reg);
                        rs_reg  <= s1_reg;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP:
                begin
                    if (mb_reg == '0 || md_reg == '0
                        || (op_reg == OP_DIV && mc_reg == '0))
                    begin
                        inf_reg <= 1'b1;
                    end
                    else if (op_reg == OP_CMP)
                    begin
                        if (cs_num != '0)
                        begin
                            ord_reg <= cs_sign ? 2'b11 : 2'b01;
                        end
                    end
                    else if (op_reg == OP_MUL || op_reg == OP_DIV)
                    begin
                        num_reg <= SW'(p0_reg);
                        den_reg <= p2_reg;
                        rs_reg  <= s1_reg ^ s2_reg;
                    end
                    else
                    begin
                        num_reg <= cs_num;
                        den_reg <= p2_reg;
                        rs_reg  <= cs_sign;
                    end
                end
                default:
                begin
                end
            endcase
        end
        // binary gcd: phase 0 strips common twos, then twos of x; phase 1 subtract loop
        if (cmd.gcd_init)
        begin
            x_reg   <= num_reg;
            y_reg   <= SW'(den_reg);
            sh_reg  <= '0;
            gph_reg <= 1'b0;
        end
        else if (cmd.gcd_step)
        begin
            if (!gph_reg)
            begin
                if (((x_reg | y_reg) & SW'(1)) == '0)
                begin
                    x_reg  <= x_reg >> 1;
                    y_reg  <= ys;
                    sh_reg <= sh_reg + 1'b1;
                end
                else if (!x_reg[0])
                begin
                    x_reg <= x_reg >> 1;
                end
                else
                begin
                    gph_reg <= 1'b1;
                end
            end
            else if (!y_reg[0])
            begin
                y_reg <= ys;
            end
            else
            begin
                x_reg <= xs;
                y_reg <= yd;
            end
        end
        // restoring divide, numerator then denominator
        if (cmd.div_init)
        begin
            g_reg    <= x_reg << sh_reg;
            rem_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            dsel_reg <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            if (cnt_reg == (CW+1)'(SW))
            begin
                qn_reg   <= quo_reg;
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= '0;
                dsel_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (!trial[SW])
                begin
                    rem_reg <= trial[SW-1:0];
                    quo_reg <= {quo_reg[SW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[SW-2:0], div_bit};
                    quo_reg <= {quo_reg[SW-2:0], 1'b0};
                end
            end
        end
    end

    assign sts.early    = inf_reg || (num_reg == '0);
    assign sts.gcd_done = gph_reg && (y_reg == '0);
    assign sts.div_done = dsel_reg && (cnt_reg == (CW+1)'(SW));

    logic zero_res;
    logic [SW-1:0] nq;
    assign zero_res = (num_reg == '0);
    assign nq       = rs_reg ? (~qn_reg + 1'b1) : qn_reg;

    always_comb
    begin
        if (inf_reg)
        begin
            result_num = '0;
            result_den = '0;
            status     = 1'b1;
            order      = '0;
        end
        else if (zero_res)
        begin
            result_num = '0;
            result_den = DEN_W'(1);
            status     = 1'b0;
            order      = ord_reg;
        end
        else
        begin
            result_num = NUM_W'(nq);
            result_den = DEN_W'(quo_reg);
            status     = 1'b0;
            order      = ord_reg;
        end
    end

endmodule

// ----- src/rfa_checker.sv -----
module rfa_props
    import rfa_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [DEN_W-1:0]  result_den,
    input logic              status,
    input logic signed [1:0] order
);

    // one word in flight: no intake while a result is shown
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("intake open while result pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_den))
        else $error("stalled result changed");

    a_inf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> result_den == '0 && order == 2'sd0)
        else $error("infinite word malformed");

    a_den: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status |-> result_den != '0)
        else $error("zero denominator on finite word");

    a_acc: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("accepted word did not close intake");

endmodule

bind rational_fraction_alu_core rfa_props u_rfa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_den (result_den),
    .status     (status),
    .order      (order)
);

// ----- verif/rfa_checker.sv -----
module rfa_checker
    import rfa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [OP_W-1:0]         operation,
    input  logic signed [15:0]      first_num,
    input  logic signed [15:0]      first_den,
    input  logic signed [15:0]      second_num,
    input  logic signed [15:0]      second_den,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [NUM_W-1:0] result_num,
    input  logic [DEN_W-1:0]        result_den,
    input  logic                    status,
    input  logic signed [1:0]       order,
    output int                      fail_count,
    output int                      pending
);

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             inf;
        logic [1:0]       ord;
    } fraction_res_t;

    fraction_res_t expected_q[$];

    assign pending = expected_q.size();

    function automatic logic [63:0] mag16(logic [15:0] v);
        return v[15] ? 64'(17'h10000 - v) : 64'(v);
    endfunction

    function automatic logic [63:0] gcd_of(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic fraction_res_t evaluate(logic [OP_W-1:0] op, logic [15:0] a,
                                               logic [15:0] b, logic [15:0] c,
                                               logic [15:0] d);
        fraction_res_t r;
        logic [63:0] ma, mb, mc, md, num, den, x, y, g;
        logic s1, s2, s2x, rs, inf, ts;
        logic [1:0] ord;
        ma = mag16(a);
        mb = mag16(b);
        mc = mag16(c);
        md = mag16(d);
        s1 = a[15] ^ b[15];
        s2 = c[15] ^ d[15];
        num = 0;
        den = 1;
        rs = 0;
        inf = 0;
        ord = 0;
        if (op == OP_REDUCE)
        begin
            if (mb == 0) inf = 1;
            else
            begin
                num = ma;
                den = mb;
                rs = s1;
            end
        end
        else if (op <= OP_CMP)
        begin
            if (mb == 0 || md == 0) inf = 1;
            else if (op == OP_ADD || op == OP_SUB || op == OP_CMP)
            begin
                s2x = (op == OP_ADD) ? s2 : !s2;
                x = ma * md;
                y = mc * mb;
                if (s1 == s2x)
                begin
                    num = x + y;
                    ts = s1;
                end
                else if (x >= y)
                begin
                    num = x - y;
                    ts = s1;
                end
                else
                begin
                    num = y - x;
                    ts = s2x;
                end
                if (num == 0) ts = 0;
                if (op == OP_CMP)
                begin
                    if (num != 0) ord = ts ? 2'b11 : 2'b01;
                    num = 0;
                end
                else
                begin
                    rs = ts;
                    den = mb * md;
                end
            end
            else if (op == OP_MUL)
            begin
                num = ma * mc;
                den = mb * md;
                rs = s1 ^ s2;
            end
            else if (mc == 0) inf = 1;
            else
            begin
                num = ma * md;
                den = mb * mc;
                rs = s1 ^ s2;
            end
        end
        if (inf)
            return '{num: '0, den: '0, inf: 1'b1, ord: 2'b00};
        if (num == 0)
        begin
            den = 1;
            rs = 0;
        end
        else
        begin
            g = gcd_of(num, den);
            num = num / g;
            den = den / g;
        end
        r.num = rs ? NUM_W'(-num) : NUM_W'(num);
        r.den = DEN_W'(den);
        r.inf = 0;
        r.ord = ord;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fraction_res_t e;
        if (!rst_n)
        begin
            expected_q.delete();
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_q.push_back(evaluate(operation, first_num, first_den,
                                              second_num, second_den));
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10) $display("unexpected result word");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e.num !== result_num || e.den !== result_den ||
                        e.inf !== status || e.ord !== order)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: exp %0d/%0d st%0d ord%0d got %0d/%0d st%0d ord%0d",
                                     $signed(e.num), e.den, e.inf, $signed(e.ord),
                                     result_num, result_den, status, order);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- verif/tb.sv -----
module tb;
    import rfa_pkg::*;

    logic clk, rst_n, in_valid, in_stall, out_valid, out_stall, status;
    logic [OP_W-1:0] operation;
    logic signed [15:0] first_num, first_den, second_num, second_den;
    logic signed [NUM_W-1:0] result_num;
    logic [DEN_W-1:0] result_den;
    logic signed [1:0] order;
    int fail_count, pending;
    logic hold_off = 0;
    logic sender_done = 0;

    rational_fraction_alu_core #(.OPERAND_WIDTH(16)) dut (.*);

    rfa_checker chk (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
    end

    initial
    begin
        #12000000;
        $display("rational_fraction_alu_core regression: fail");
        $finish;
    end

    // receiver: random stall per word, plus one long hold-off
    initial
    begin
        int n;
        out_stall = 1;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_stall <= 1;
                repeat (3000) @(posedge clk);
                hold_off = 0;
            end
            n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            if (n > 0)
            begin
                out_stall <= 1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'sd0;
            1: return 16'h8000;
            2: return 16'h7fff;
            3: return 16'hffff;
            4: return 16'($urandom_range(1, 12));
            5: return -16'($urandom_range(1, 12));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_word(logic [OP_W-1:0] op, logic [15:0] a, logic [15:0] b,
                             logic [15:0] c, logic [15:0] d, bit gaps);
        int n;
        n = (gaps && $urandom_range(0, 2) != 0) ? $urandom_range(0, 16) : 0;
        if (n > 0)
        begin
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1;
        operation <= op;
        first_num <= a;
        first_den <= b;
        second_num <= c;
        second_den <= d;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] a, b, c, d;
        in_valid = 0;
        operation = OP_ADD;
        first_num = 0;
        first_den = 1;
        second_num = 0;
        second_den = 1;
        @(posedge rst_n);
        @(posedge clk);
        for (int k = 0; k < 8; k++)
            send_word(OP_W'(k), 16'sd3, -16'sd6, 16'sd5, 16'sd10, 0);
        send_word(OP_ADD, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0);
        send_word(OP_MUL, 16'h8000, 16'hffff, 16'h8000, 16'hffff, 0);
        send_word(OP_DIV, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 0);
        send_word(OP_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd1, 0);
        send_word(OP_DIV, 16'sd1, 16'sd2, 16'sd0, 16'sd3, 0);
        send_word(OP_REDUCE, 16'sd4, 16'sd8, 16'sd1, 16'sd0, 0);
        send_word(OP_REDUCE, 16'sd4, 16'sd0, 16'sd1, 16'sd1, 0);
        send_word(OP_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2, 0);
        send_word(OP_CMP, 16'sd1, -16'sd2, -16'sd1, 16'sd2, 0);
        send_word(OP_CMP, -16'sd1, 16'sd3, 16'sd1, 16'sd2, 0);
        send_word(OP_CMP, 16'sd2, 16'sd3, 16'sd1, -16'sd2, 0);
        send_word(OP_CMP, 16'sd0, 16'sd0, 16'sd1, 16'sd2, 0);
        send_word(OP_ADD, 16'sd0, 16'sd5, 16'sd0, -16'sd7, 0);
        hold_off = 1;
        for (int k = 0; k < 1930; k++)
        begin
            if (k == 900)
            begin
                // pause until every word has drained
                in_valid <= 0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            a = pick_value();
            b = pick_value();
            c = pick_value();
            d = pick_value();
            send_word(OP_W'($urandom_range(0, 9) == 0 ? $urandom_range(6, 7)
                                                      : $urandom_range(0, 5)),
                      a, b, c, d, k % 200 > 40);
        end
        in_valid <= 0;
        sender_done = 1;
    end

    initial
    begin
        wait (sender_done);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("rational_fraction_alu_core regression: pass");
        else
            $display("rational_fraction_alu_core regression: fail");
        $finish;
    end

endmodule

// ----- rational_fraction_alu_core.f -----
src/rfa_pkg.sv
src/rfa_ctrl.sv
src/rfa_datapath.sv
src/rational_fraction_alu_core.sv
src/rfa_checker.sv
verif/rfa_checker.sv
verif/tb.sv
